>>> design/sfind_pkg.sv
// Shared types and constants for the subrecord finder.
// No dependencies; used by every module under design/.
package sfind_pkg;

	// Signature of the size carrier subrecord "XXXX"
	localparam logic [31:0] SIG_EXTENDED = 32'h5858_5858;
	// Reset target: "NAME", first character in the low byte
	localparam logic [31:0] SIG_NAME     = 32'h454D_414E;

	// Extraction modes; the unused code behaves as raw
	localparam logic [1:0] MODE_RAW    = 2'd0;
	localparam logic [1:0] MODE_WORD   = 2'd1;
	localparam logic [1:0] MODE_STRING = 2'd2;

	// Configuration register indexes
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 1'd1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SKIP   = 3'd1,
		PH_EXT    = 3'd2,
		PH_MATCH  = 3'd3,
		PH_TAIL   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_TRUNCATED = 3'd2,
		ST_BAD_EXT   = 3'd3,
		ST_TOO_SHORT = 3'd4
	} status_t;

	// One result item
	typedef struct packed {
		logic        kind;       // 0 payload byte, 1 status
		logic [7:0]  data_byte;
		logic [31:0] word;
		status_t     status;
		logic        last;
	} res_t;

	// Results of one input byte: up to a payload byte followed by a status
	typedef struct packed {
		logic [1:0] cnt;
		res_t       a;
		res_t       b;
	} push_t;

endpackage

>>> design/subrecord_finder_core.sv
// Subrecord finder: scans a record body byte by byte for the target
// subrecord. A request passes the parser's input register and then the
// result queue before its first result; one byte per cycle sustained
// while the queue has room, and a byte giving two results queues both.
// Asynchronous active-low reset: target NAME, word mode, empty queue.
module subrecord_finder_core #(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [sfind_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	// Record bytes in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] record_byte
	input  logic                            s_axis_tlast,  // record_end
	// Results out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] payload_byte, [39:8] found_word, [42:40] status_code, [47:43] zero
	output logic [47:0]                     m_axis_tdata,
	output logic                            m_axis_tuser,  // item_kind
	output logic                            m_axis_tlast   // last_of_run
);
	import sfind_pkg::*;

	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	logic [31:0]   target_q;
	logic [1:0]    mode_q;
	logic          busy;
	push_t         push;
	res_t          head;
	logic [CW-1:0] fifo_cnt;
	logic [CW:0]   need;
	logic          accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= SIG_NAME;
			mode_q   <= MODE_WORD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET: target_q <= cfg_data;
				REG_MODE:   mode_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Room for this request plus the one still in the parser
	assign need = (CW+1)'(fifo_cnt) + (busy ? (CW+1)'(2) : '0) + (CW+1)'(2);
	assign s_axis_tready = (need <= (CW+1)'(FIFO_DEPTH));
	assign accept = s_axis_tvalid & s_axis_tready;

	sfind_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_byte  (s_axis_tdata),
		.in_end   (s_axis_tlast),
		.target   (target_q),
		.mode     (mode_q),
		.busy     (busy),
		.push     (push)
	);

	sfind_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (head),
		.count     (fifo_cnt)
	);

	assign m_axis_tdata = {5'd0, head.status, head.word, head.data_byte};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

	// Checks
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> (!push.a.kind && push.b.kind))
		else $error("second result of a byte is not a status");

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
		else $error("status and last flag disagree");

endmodule

>>> design/sfind_parser.sv
// Input register and record parser: walks the subrecord headers and
// produces up to two result items per byte. Depends on sfind_pkg.
module sfind_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_end,
	input  logic [31:0]          target,
	input  logic [1:0]           mode,
	output logic                 busy,
	output sfind_pkg::push_t     push
);
	import sfind_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Record state
	phase_t      phase_q, phase_n;
	logic [2:0]  hdr_cnt_q, hdr_cnt_n;
	logic [31:0] sig_q, sig_n;
	logic [15:0] size_q, size_n;
	logic        pend_q, pend_n;
	logic [31:0] ext_q, ext_n;
	logic [31:0] rem_q, rem_n;
	logic [31:0] word_q, word_n;
	logic [2:0]  emit_q, emit_n;

	// Step results
	logic        pay_v, sta_v, fin;
	status_t     sta_code;
	logic [31:0] sta_word;
	logic [31:0] hdr_size;
	res_t        pay_item, sta_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

	assign busy = valid_s1;

	// Next record state and result items for the registered byte
	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		sig_n     = sig_q;
		size_n    = size_q;
		pend_n    = pend_q;
		ext_n     = ext_q;
		rem_n     = rem_q;
		word_n    = word_q;
		emit_n    = emit_q;
		pay_v     = 1'b0;
		sta_v     = 1'b0;
		fin       = 1'b0;
		sta_code  = ST_FOUND;
		sta_word  = '0;
		hdr_size  = pend_q ? ext_q : {16'd0, byte_s1, size_q[15:8]};

		if (valid_s1) begin
			case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q < 3'd4) begin
						sig_n = {byte_s1, sig_q[31:8]};
					end else begin
						size_n = {byte_s1, size_q[15:8]};
					end
					hdr_cnt_n = hdr_cnt_q + 3'd1;
					if (hdr_cnt_q == 3'd5) begin
						hdr_cnt_n = 3'd0;
						pend_n    = 1'b0;
						if (sig_q == SIG_EXTENDED) begin
							if (hdr_size != 32'd4) begin
								sta_v    = 1'b1;
								sta_code = ST_BAD_EXT;
								phase_n  = PH_DONE;
							end else begin
								phase_n = PH_EXT;
								rem_n   = 32'd4;
								ext_n   = '0;
							end
						end else if (sig_q == target) begin
							phase_n = PH_MATCH;
							rem_n   = hdr_size;
							emit_n  = 3'd0;
							word_n  = '0;
							fin     = (hdr_size == 32'd0);
						end else if (hdr_size != 32'd0) begin
							phase_n = PH_SKIP;
							rem_n   = hdr_size;
						end
					end
				end
				PH_SKIP: begin
					rem_n = rem_q - 32'd1;
					if (rem_q == 32'd1) begin
						phase_n = PH_HEADER;
					end
				end
				PH_EXT: begin
					ext_n = {byte_s1, ext_q[31:8]};
					rem_n = rem_q - 32'd1;
					if (rem_q == 32'd1) begin
						pend_n  = 1'b1;
						phase_n = PH_HEADER;
					end
				end
				PH_MATCH: begin
					rem_n = rem_q - 32'd1;
					if (mode == MODE_WORD) begin
						if (emit_q < 3'd4) begin
							word_n = {byte_s1, word_q[31:8]};
							emit_n = emit_q + 3'd1;
						end
					end else if (mode == MODE_STRING) begin
						if (byte_s1 == 8'd0) begin
							phase_n = PH_TAIL;
						end else begin
							pay_v = 1'b1;
							if (emit_q < 3'd4) begin
								emit_n = emit_q + 3'd1;
							end
						end
					end else begin
						pay_v = 1'b1;
					end
					fin = (rem_q == 32'd1);
				end
				PH_TAIL: begin
					rem_n = rem_q - 32'd1;
					fin   = (rem_q == 32'd1);
				end
				default: begin
				end
			endcase

			// Close a completed match
			if (fin) begin
				sta_v   = 1'b1;
				phase_n = PH_DONE;
				if (mode == MODE_WORD) begin
					if (emit_n >= 3'd4) begin
						sta_word = word_n;
					end else begin
						sta_code = ST_TOO_SHORT;
					end
				end else if (mode == MODE_STRING) begin
					sta_code = (emit_n != 3'd0) ? ST_FOUND : ST_TOO_SHORT;
				end
			end

			// End of record: report if still open, then start afresh
			if (end_s1) begin
				if (phase_n != PH_DONE) begin
					sta_v    = 1'b1;
					sta_word = '0;
					sta_code = (phase_n == PH_HEADER) ? ST_NOT_FOUND : ST_TRUNCATED;
				end
				phase_n   = PH_HEADER;
				hdr_cnt_n = 3'd0;
				sig_n     = '0;
				size_n    = '0;
				pend_n    = 1'b0;
				ext_n     = '0;
				rem_n     = '0;
				word_n    = '0;
				emit_n    = 3'd0;
			end
		end
	end

	// Pack results, payload byte ahead of status
	always_comb begin
		pay_item           = '0;
		pay_item.kind      = 1'b0;
		pay_item.data_byte = byte_s1;
		pay_item.status    = ST_FOUND;

		sta_item        = '0;
		sta_item.kind   = 1'b1;
		sta_item.word   = sta_word;
		sta_item.status = sta_code;
		sta_item.last   = 1'b1;

		push.a   = pay_v ? pay_item : sta_item;
		push.b   = sta_item;
		push.cnt = {1'b0, pay_v} + {1'b0, sta_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 3'd0;
			sig_q     <= '0;
			size_q    <= '0;
			pend_q    <= 1'b0;
			ext_q     <= '0;
			rem_q     <= '0;
			word_q    <= '0;
			emit_q    <= 3'd0;
		end else begin
			phase_q   <= phase_n;
			hdr_cnt_q <= hdr_cnt_n;
			sig_q     <= sig_n;
			size_q    <= size_n;
			pend_q    <= pend_n;
			ext_q     <= ext_n;
			rem_q     <= rem_n;
			word_q    <= word_n;
			emit_q    <= emit_n;
		end
	end

endmodule

>>> design/sfind_out_fifo.sv
// Result queue: takes up to two result items a cycle, hands out one when the reader is ready.
// Depends on sfind_pkg. DEPTH must be a power of two, at least 4.
module sfind_out_fifo #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfind_pkg::push_t              push,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sfind_pkg::res_t               out_item,
	output logic [$clog2(DEPTH+1)-1:0]    count
);
	import sfind_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t          mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_item  = mem[rd_q];
	assign count     = cnt_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.a;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + AW'(1)] <= push.b;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.cnt);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule
